@@ sv/five_bit_text_encoder_assert.svh @@
// Assertion macros used by the encoder top level.
`ifndef FIVE_BIT_TEXT_ENCODER_ASSERT_SVH
`define FIVE_BIT_TEXT_ENCODER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define FBTE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fbte assertion failed");

// Next-cycle implication, checked out of reset.
`define FBTE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fbte assertion failed");

`endif

@@ sv/fbte_pkg.sv @@
package fbte_pkg;

    localparam int GROUP_W     = 5;
    localparam int MAX_RESULTS = 5;

    localparam logic [7:0] NEWLINE_CHAR = 8'd10;
    localparam logic [7:0] CHAR_A       = 8'd65;
    localparam logic [7:0] DIGIT_OFS    = 8'd22;
    localparam logic [4:0] LAST_LETTER  = 5'd25;
    localparam logic [7:0] LW_RESET     = 8'd72;

    typedef struct packed {
        logic [3:0] bits;
        logic [2:0] held;
        logic [7:0] col;
        logic       any;
    } fbte_state_t;

    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] chars;
        logic [2:0]                  count;
    } fbte_result_t;

    function automatic logic [7:0] sym_to_char(input logic [4:0] v);
        logic [7:0] c;
        if (v <= LAST_LETTER)
            c = CHAR_A + {3'd0, v};
        else
            c = {3'd0, v} + DIGIT_OFS;
        return c;
    endfunction

endpackage

@@ sv/fbte_step.sv @@
// Works out the characters caused by one item, up to five, and the state it leaves.
module fbte_step (
    input  fbte_pkg::fbte_state_t  st,
    input  logic [7:0]             row_len,
    input  logic [7:0]             data_byte,
    input  logic                   is_last_byte,
    output fbte_pkg::fbte_state_t  st_next,
    output fbte_pkg::fbte_result_t res
);

    always_comb
    begin
        logic [11:0] acc;
        logic [3:0]  tot;
        logic [12:0] mask;
        logic        two;
        logic [2:0]  rem;
        logic [4:0]  rem_mask;
        logic [3:0]  rem_bits;
        logic [2:0][4:0] syms;
        logic [2:0]  sv;
        logic [7:0]  col;
        logic        any;
        logic [2:0]  k;

        tot = {1'b0, st.held} + 4'd8;
        if (tot > 4'd12)
            tot = 4'd12;
        mask = (13'd1 << tot) - 13'd1;
        acc  = {st.bits, data_byte} & mask[11:0];

        two = (tot >= 4'd10);
        rem = two ? 3'(tot - 4'd10) : 3'(tot - 4'd5);
        rem_mask = (5'd1 << rem) - 5'd1;
        rem_bits = acc[3:0] & rem_mask[3:0];

        syms[0] = 5'(acc >> (tot - 4'd5));
        syms[1] = 5'(acc >> (tot - 4'd10));
        syms[2] = 5'({1'b0, rem_bits} << (3'd5 - rem));
        sv[0]   = 1'b1;
        sv[1]   = two;
        sv[2]   = is_last_byte && (rem != 3'd0);

        col = st.col;
        any = st.any;
        k   = 3'd0;
        res.chars = '0;

        for (int i = 0; i < 3; i++)
        begin
            if (sv[i])
            begin
                if (any && col == 8'd0)
                begin
                    if (k < 3'(fbte_pkg::MAX_RESULTS))
                        res.chars[k] = fbte_pkg::NEWLINE_CHAR;
                    k = k + 3'd1;
                end
                if (k < 3'(fbte_pkg::MAX_RESULTS))
                    res.chars[k] = fbte_pkg::sym_to_char(syms[i]);
                k   = k + 3'd1;
                any = 1'b1;
                col = col + 8'd1;
                if (col == row_len)
                    col = 8'd0;
            end
        end

        if (is_last_byte)
        begin
            if (k < 3'(fbte_pkg::MAX_RESULTS))
                res.chars[k] = fbte_pkg::NEWLINE_CHAR;
            k = k + 3'd1;
        end

        // characters past five results (newlines and a symbol) are dropped at tiny line widths
        res.count = (k > 3'(fbte_pkg::MAX_RESULTS)) ? 3'(fbte_pkg::MAX_RESULTS) : k;

        if (is_last_byte)
            st_next = '0;
        else
        begin
            st_next.bits = rem_bits;
            st_next.held = rem;
            st_next.col  = col;
            st_next.any  = any;
        end
    end

endmodule

@@ sv/five_bit_text_encoder.sv @@
// The first character of an item is offered in the cycle after the item is accepted.
// Throughput: one character per cycle while out_ready is high; an item causes 1 to 5
//   characters, which leave one at a time through the single character output port.
// The next item is taken in the cycle the previous item's last character is taken.
// Reset (rst_n, async, active low): bit buffer and column cleared, queue emptied, line width 72.
`include "five_bit_text_encoder_assert.svh"

module five_bit_text_encoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       is_last_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_char,
    output logic       last_of_run
);

    fbte_pkg::fbte_state_t  st_reg;
    fbte_pkg::fbte_state_t  st_next;
    fbte_pkg::fbte_result_t res;
    logic [7:0]             lw_reg;
    logic [fbte_pkg::MAX_RESULTS-1:0][7:0] q_reg;
    logic [2:0]             left_reg;
    logic                   in_fire;
    logic                   out_fire;

    fbte_step u_step (
        .st          (st_reg),
        .row_len     (lw_reg),
        .data_byte   (data_byte),
        .is_last_byte(is_last_byte),
        .st_next     (st_next),
        .res         (res)
    );

    assign cfg_ready   = 1'b1;
    assign out_valid   = (left_reg != 3'd0);
    assign out_char    = q_reg[0];
    assign last_of_run = (left_reg == 3'd1);
    assign in_ready    = (left_reg == 3'd0) || ((left_reg == 3'd1) && out_ready);
    assign in_fire     = in_valid && in_ready;
    assign out_fire    = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= '0;
            lw_reg   <= fbte_pkg::LW_RESET;
            left_reg <= 3'd0;
        end
        else
        begin
            if (cfg_valid)
                lw_reg <= cfg_data;
            if (in_fire)
            begin
                st_reg   <= st_next;
                left_reg <= res.count;
            end
            else if (out_fire)
                left_reg <= left_reg - 3'd1;
        end
    end

    // character queue, head at entry 0
    always_ff @(posedge clk)
    begin
        if (in_fire)
            q_reg <= res.chars;
        else if (out_fire)
            q_reg <= {8'd0, q_reg[fbte_pkg::MAX_RESULTS-1:1]};
    end

    `FBTE_ASSERT_NOW(a_held_range, 1'b1, st_reg.held <= 3'd4)
    `FBTE_ASSERT_NOW(a_idle_col, !st_reg.any, st_reg.col == 8'd0)
    `FBTE_ASSERT_NEXT(a_item_out, in_fire, out_valid)
    `FBTE_ASSERT_NEXT(a_drain, out_fire && last_of_run && !in_fire, !out_valid)

endmodule

@@ tb/fbte_stream_checker.sv @@
module fbte_stream_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       is_last_byte,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] out_char,
    input  logic       last_of_run,
    output int         errors,
    output int         pending,
    output int         checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
    } glyph_t;

    glyph_t     expected_glyphs[$];
    glyph_t     want;

    // shadow copy of the encoder state
    logic [7:0] row_len;
    logic [3:0] spare_bits;
    logic [2:0] spare_count;
    logic [7:0] col;
    logic       started;

    logic [7:0] burst[fbte_pkg::MAX_RESULTS];
    int         burst_n;

    task automatic put_char(input logic [7:0] c);
        if (burst_n < fbte_pkg::MAX_RESULTS)
        begin
            burst[burst_n] = c;
            burst_n++;
        end
    endtask

    task automatic put_group(input logic [4:0] v);
        if (started && col == 8'd0)
            put_char(fbte_pkg::NEWLINE_CHAR);
        put_char(v <= fbte_pkg::LAST_LETTER ? fbte_pkg::CHAR_A + {3'b000, v}
                                            : {3'b000, v} + fbte_pkg::DIGIT_OFS);
        started = 1'b1;
        col = col + 8'd1;
        // width 0 never matches here, so the column wraps at 256
        if (col == row_len)
            col = 8'd0;
    endtask

    task automatic encode_byte(input logic [7:0] b, input logic fin);
        int acc;
        int nbits;
        burst_n = 0;
        nbits = spare_count + 8;
        acc = (int'(spare_bits) << 8) | int'(b);
        acc &= (1 << nbits) - 1;
        while (nbits >= fbte_pkg::GROUP_W)
        begin
            put_group(5'(acc >> (nbits - fbte_pkg::GROUP_W)));
            nbits -= fbte_pkg::GROUP_W;
            acc &= (1 << nbits) - 1;
        end
        if (fin)
        begin
            if (nbits > 0)
                put_group(5'(acc << (fbte_pkg::GROUP_W - nbits)));
            put_char(fbte_pkg::NEWLINE_CHAR);
            spare_bits = 4'd0;
            spare_count = 3'd0;
            col = 8'd0;
            started = 1'b0;
        end
        else
        begin
            spare_bits = acc[3:0];
            spare_count = 3'(nbits);
        end
        for (int i = 0; i < burst_n; i++)
            expected_glyphs.push_back('{ch: burst[i], fin: (i == burst_n - 1)});
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_len = fbte_pkg::LW_RESET;
            spare_bits = 4'd0;
            spare_count = 3'd0;
            col = 8'd0;
            started = 1'b0;
            expected_glyphs.delete();
            errors = 0;
            checked = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                row_len = cfg_data;
            if (in_valid && in_ready)
                encode_byte(data_byte, is_last_byte);
            if (out_valid && out_ready)
            begin
                checked++;
                if (expected_glyphs.size() == 0)
                begin
                    errors++;
                    $display("%0t: char %0d (last %0b) arrived with nothing expected",
                             $time, out_char, last_of_run);
                end
                else
                begin
                    want = expected_glyphs.pop_front();
                    if (out_char !== want.ch || last_of_run !== want.fin)
                        errors++;
                    if (out_char !== want.ch)
                        $display("%0t: out_char expected %0d got %0d",
                                 $time, want.ch, out_char);
                    if (last_of_run !== want.fin)
                        $display("%0t: last_of_run expected %0b got %0b",
                                 $time, want.fin, last_of_run);
                end
            end
            pending = expected_glyphs.size();
        end
    end

endmodule

@@ tb/five_bit_text_encoder_tb.sv @@
module five_bit_text_encoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;
    localparam int ITEM_TARGET = 280;

    logic       clk;
    logic       rst_n;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_data;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] data_byte;
    logic       is_last_byte;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] out_char;
    logic       last_of_run;

    int         errors;
    int         pending;
    int         checked;

    bit         steady;
    int         stall_cycles;
    int         n_bytes;
    int         n_msgs;
    int         n_cfg;
    int         msg_left;
    int         phase_len;

    five_bit_text_encoder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .is_last_byte(is_last_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_char    (out_char),
        .last_of_run (last_of_run)
    );

    fbte_stream_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .is_last_byte(is_last_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_char    (out_char),
        .last_of_run (last_of_run),
        .errors      (errors),
        .pending     (pending),
        .checked     (checked)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(negedge clk)
        out_ready <= steady || ($urandom_range(0, 99) >= 36);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                stall_cycles <= 0;
            else
            begin
                stall_cycles <= stall_cycles + 1;
                if (stall_cycles >= STALL_LIMIT)
                begin
                    $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
                    $display("SCOREBOARD MISMATCH");
                    $finish;
                end
            end
        end
    end

    // called right after an accepting edge; holds valid high when no gap is drawn
    task automatic push_byte(input logic [7:0] b, input logic fin);
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < 36)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        is_last_byte <= fin;
        do
            @(posedge clk);
        while (!in_ready);
        n_bytes++;
        if (fin)
            n_msgs++;
    endtask

    // line width changes only once every pending char has come out
    task automatic set_width(input logic [7:0] w);
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= w;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        n_cfg++;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = 8'd0;
        in_valid = 1'b0;
        data_byte = 8'd0;
        is_last_byte = 1'b0;
        out_ready = 1'b0;
        steady = 1'b0;
        stall_cycles = 0;
        n_bytes = 0;
        n_msgs = 0;
        n_cfg = 0;
        msg_left = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset width: single byte, exact 40-bit message, padded tail
        push_byte(8'hFF, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hA5, 1'b0);
        push_byte(8'h5A, 1'b0);
        push_byte(8'hC3, 1'b1);
        push_byte(8'h84, 1'b0);
        push_byte(8'h21, 1'b1);
        // width 1: last byte with four spare bits overflows the burst
        set_width(8'd1);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h7E, 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(8'h80, 1'b1);
        set_width(8'd2);
        push_byte(8'hF0, 1'b0);
        push_byte(8'h0F, 1'b0);
        push_byte(8'hAA, 1'b0);
        push_byte(8'h55, 1'b1);
        set_width(8'd0);
        push_byte(8'h12, 1'b0);
        push_byte(8'h34, 1'b1);
        set_width(8'd255);
        push_byte(8'hC6, 1'b1);

        // one long line at width 0, narrowed below the column midway so it wraps at 256
        set_width(8'd0);
        for (int i = 0; i < 100; i++)
            push_byte(8'($urandom), 1'b0);
        set_width(8'd120);
        steady = 1'b1;
        for (int i = 0; i < 65; i++)
            push_byte(8'($urandom), i == 64);
        steady = 1'b0;

        while (n_bytes < ITEM_TARGET)
        begin
            case ($urandom_range(0, 5))
                0: set_width(8'd1);
                1: set_width(8'd2);
                2: set_width(8'd255);
                3: set_width(8'd0);
                default: set_width(8'($urandom_range(3, 80)));
            endcase
            phase_len = $urandom_range(10, 30);
            for (int i = 0; i < phase_len; i++)
            begin
                if (msg_left == 0)
                    msg_left = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 40)
                                                           : $urandom_range(1, 12);
                msg_left--;
                push_byte(8'($urandom), msg_left == 0);
            end
        end
        while (msg_left > 0)
        begin
            msg_left--;
            push_byte(8'($urandom), msg_left == 0);
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (10) @(posedge clk);

        $display("covered %0d bytes in %0d messages over %0d line-width writes",
                 n_bytes, n_msgs, n_cfg);
        $display("widths 0, 1, 2, 255, a mid-line narrowing and random; %0d chars checked",
                 checked);
        if (errors == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+sv
sv/fbte_pkg.sv
sv/fbte_step.sv
sv/five_bit_text_encoder.sv
tb/fbte_stream_checker.sv
tb/five_bit_text_encoder_tb.sv
